// ===== design/assert_macros.svh =====
// Assertion macros used by the top RTL file of the byte vector similarity block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define BVS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bvs assertion failed");

// Check that a condition never holds at a clock edge outside reset.
`define BVS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bvs forbidden condition seen");

`endif

// ===== design/bvs_pkg.sv =====
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared constants, metric codes and queue types of the similarity block.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int LANES       = 8;
  localparam int FIELD_LANES = 8;
  localparam int ACC_BITS    = 32;
  localparam int FRAC_BITS   = 30;

  // Lane word widened so that lanes beyond the input field read as zero
  localparam int LANE_WORD_W = (LANES > FIELD_LANES) ? LANES * 8 : FIELD_LANES * 8;
  localparam int LCNT_W      = 5;

  localparam int PROD_W  = 20;
  localparam int NORM_W  = 17;
  localparam int LOG_L   = (LANES > 1) ? $clog2(LANES) : 0;
  localparam int DSUM_W  = PROD_W + LOG_L + 1;
  localparam int NSUM_W  = NORM_W + LOG_L;

  localparam int PROD_BITS  = 2 * ACC_BITS;
  localparam int SQRT_STEPS = ACC_BITS;
  localparam int DIV_W      = ACC_BITS + FRAC_BITS;
  localparam int STEP_W     = $clog2(DIV_W);

  localparam logic [2:0] METRIC_DOT_S8 = 3'd0;
  localparam logic [2:0] METRIC_DOT_U8 = 3'd1;
  localparam logic [2:0] METRIC_L2_S8  = 3'd2;
  localparam logic [2:0] METRIC_L2_U8  = 3'd3;
  localparam logic [2:0] METRIC_COS_S8 = 3'd4;
  localparam logic [2:0] METRIC_COS_U8 = 3'd5;

  // One classified item with its lane sums
  typedef struct packed {
    logic signed [DSUM_W-1:0] dot_part;
    logic [NSUM_W-1:0]        na_part;
    logic [NSUM_W-1:0]        nb_part;
    logic                     last;
    logic                     is_cos;
    logic                     is_signed;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

endpackage

// ===== design/bvs_front.sv =====
// ----------------------------------------------------------------------------
// bvs_front
// Accepts lane beats, decodes the metric and forms the per-beat lane sums.
// ----------------------------------------------------------------------------
module bvs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       metric_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [63:0]      a_lanes_i,
  input  logic [63:0]      b_lanes_i,
  input  logic [3:0]       valid_count_i,
  input  logic             last_i,
  output logic             push_o,
  output bvs_pkg::entry_t  entry_o,
  input  logic             full_i,
  output logic             hold_o
);

  logic                      valid_q;
  logic                      last_q, cos_q, signed_q;
  logic signed [bvs_pkg::PROD_W-1:0] dp_q [bvs_pkg::LANES];
  logic [bvs_pkg::NORM_W-1:0]        na_q [bvs_pkg::LANES];
  logic [bvs_pkg::NORM_W-1:0]        nb_q [bvs_pkg::LANES];
  logic signed [bvs_pkg::PROD_W-1:0] dp_d [bvs_pkg::LANES];
  logic [bvs_pkg::NORM_W-1:0]        na_d [bvs_pkg::LANES];
  logic [bvs_pkg::NORM_W-1:0]        nb_d [bvs_pkg::LANES];

  logic        is_signed, is_l2, is_cos, accept;
  logic [bvs_pkg::LCNT_W-1:0]      cnt;
  logic [bvs_pkg::LANE_WORD_W-1:0] a_w, b_w;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !valid_q || !full_i;
  assign push_o     = valid_q && !full_i;
  assign hold_o     = valid_q;

  // Decode the metric; unused codes fall back to signed dot
  always_comb begin
    unique case (metric_i)
      bvs_pkg::METRIC_DOT_U8: begin is_signed = 1'b0; is_l2 = 1'b0; is_cos = 1'b0; end
      bvs_pkg::METRIC_L2_S8:  begin is_signed = 1'b1; is_l2 = 1'b1; is_cos = 1'b0; end
      bvs_pkg::METRIC_L2_U8:  begin is_signed = 1'b0; is_l2 = 1'b1; is_cos = 1'b0; end
      bvs_pkg::METRIC_COS_S8: begin is_signed = 1'b1; is_l2 = 1'b0; is_cos = 1'b1; end
      bvs_pkg::METRIC_COS_U8: begin is_signed = 1'b0; is_l2 = 1'b0; is_cos = 1'b1; end
      default:                begin is_signed = 1'b1; is_l2 = 1'b0; is_cos = 1'b0; end
    endcase
  end

  // Clamp the lane count and widen the lane words
  assign cnt = ({1'b0, valid_count_i} > bvs_pkg::LCNT_W'(bvs_pkg::LANES)) ?
               bvs_pkg::LCNT_W'(bvs_pkg::LANES) : {1'b0, valid_count_i};
  assign a_w = bvs_pkg::LANE_WORD_W'(a_lanes_i);
  assign b_w = bvs_pkg::LANE_WORD_W'(b_lanes_i);

  // Form the lane products, masking lanes past the count
  always_comb begin
    logic [7:0] ab, bb;
    logic signed [9:0] av, bv, dv;
    logic signed [19:0] pab, paa, pbb, pdd;
    for (int i = 0; i < bvs_pkg::LANES; i++) begin
      ab = a_w[8*i +: 8];
      bb = b_w[8*i +: 8];
      av = is_signed ? {{2{ab[7]}}, ab} : {2'b00, ab};
      bv = is_signed ? {{2{bb[7]}}, bb} : {2'b00, bb};
      dv = av - bv;
      pab = av * bv;
      paa = av * av;
      pbb = bv * bv;
      pdd = dv * dv;
      if (bvs_pkg::LCNT_W'(i) < cnt) begin
        dp_d[i] = is_l2 ? pdd : pab;
        na_d[i] = paa[bvs_pkg::NORM_W-1:0];
        nb_d[i] = pbb[bvs_pkg::NORM_W-1:0];
      end else begin
        dp_d[i] = '0;
        na_d[i] = '0;
        nb_d[i] = '0;
      end
    end
  end

  // Hold the beat's products until the queue takes them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dp_q     <= dp_d;
      na_q     <= na_d;
      nb_q     <= nb_d;
      last_q   <= last_i;
      cos_q    <= is_cos;
      signed_q <= is_signed;
    end
  end

  // Sum the lanes into one queue entry
  always_comb begin
    entry_o.dot_part  = '0;
    entry_o.na_part   = '0;
    entry_o.nb_part   = '0;
    for (int i = 0; i < bvs_pkg::LANES; i++) begin
      entry_o.dot_part = entry_o.dot_part + bvs_pkg::DSUM_W'(dp_q[i]);
      entry_o.na_part  = entry_o.na_part + bvs_pkg::NSUM_W'(na_q[i]);
      entry_o.nb_part  = entry_o.nb_part + bvs_pkg::NSUM_W'(nb_q[i]);
    end
    entry_o.last      = last_q;
    entry_o.is_cos    = cos_q;
    entry_o.is_signed = signed_q;
  end

endmodule

// ===== design/bvs_fifo.sv =====
// ----------------------------------------------------------------------------
// bvs_fifo
// Two-entry queue of classified beats between the front and back parts.
// ----------------------------------------------------------------------------
module bvs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bvs_pkg::entry_t      entry_i,
  input  logic                 pop_i,
  output bvs_pkg::entry_t      entry_o,
  output bvs_pkg::fifo_stat_t  stat_o
);

  bvs_pkg::entry_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      count_q;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign entry_o      = mem_q[rd_q];

  // Advance the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

// ===== design/bvs_back.sv =====
// ----------------------------------------------------------------------------
// bvs_back
// Accumulates queued beats and runs the cosine root and divide finish.
// ----------------------------------------------------------------------------
module bvs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bvs_pkg::entry_t     entry_i,
  input  logic                empty_i,
  output bvs_pkg::back_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         value_o
);

  typedef enum logic [4:0] {
    ST_ACC  = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  localparam int A = bvs_pkg::ACC_BITS;
  localparam int P = bvs_pkg::PROD_BITS;
  localparam int D = bvs_pkg::DIV_W;

  state_e state_q, state_d;
  logic [A-1:0] dot_q, na_q, nb_q, dot_n, na_n, nb_n;
  logic [P-1:0] x_q, res_q, bit_q;
  logic [A-1:0] mag_q, rem_q;
  logic [D-1:0] dvd_q, quo_q;
  logic [bvs_pkg::STEP_W-1:0] step_q;
  logic neg_q, zero_q, out_valid_q, pop, out_free;
  logic [31:0] value_q, fin_value;
  logic [P-1:0] trial;
  logic [A:0]   dtrial;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop         = (state_q == ST_ACC) && !empty_i &&
                       (!entry_i.last || entry_i.is_cos || out_free);
  assign stat_o.pop  = pop;
  assign stat_o.busy = (state_q != ST_ACC);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  assign dot_n = dot_q + A'(entry_i.dot_part);
  assign na_n  = na_q + A'(entry_i.na_part);
  assign nb_n  = nb_q + A'(entry_i.nb_part);

  assign trial  = res_q + bit_q;
  assign dtrial = {rem_q, dvd_q[D-1]};

  // Saturate the quotient to one, give zero for a zero norm and restore the sign
  always_comb begin
    logic [D-1:0] qs;
    if (zero_q) begin
      qs = '0;
    end else if (quo_q > (D'(1) << bvs_pkg::FRAC_BITS)) begin
      qs = D'(1) << bvs_pkg::FRAC_BITS;
    end else begin
      qs = quo_q;
    end
    fin_value = neg_q ? (32'd0 - qs[31:0]) : qs[31:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC:  if (pop && entry_i.last && entry_i.is_cos) begin
                 state_d = ((na_n == '0) || (nb_n == '0)) ? ST_FIN : ST_MUL;
               end
      ST_MUL:  state_d = ST_SQRT;
      ST_SQRT: if (step_q == bvs_pkg::STEP_W'(bvs_pkg::SQRT_STEPS - 1)) state_d = ST_DIV;
      ST_DIV:  if (step_q == bvs_pkg::STEP_W'(D - 1)) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_ACC;
      default: state_d = ST_ACC;
    endcase
  end

  // Control: state, accumulators and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        if (entry_i.last && !entry_i.is_cos) begin
          dot_q <= '0;
          na_q  <= '0;
          nb_q  <= '0;
        end else begin
          dot_q <= dot_n;
          na_q  <= na_n;
          nb_q  <= nb_n;
        end
      end
      if ((state_q == ST_FIN) && out_free) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end
      // Load the output register on a result, drop it once taken
      if ((pop && entry_i.last && !entry_i.is_cos) ||
          ((state_q == ST_FIN) && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_SQRT || state_q == ST_DIV) && state_d == state_q) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Datapath of the finish: product, root bit by bit, restoring divide
  always_ff @(posedge clk_i) begin
    if (pop && entry_i.last && !entry_i.is_cos) value_q <= dot_n;
    if ((state_q == ST_FIN) && out_free) value_q <= fin_value;
    unique case (state_q)
      ST_ACC: begin
        neg_q  <= entry_i.is_signed && dot_n[A-1];
        mag_q  <= (entry_i.is_signed && dot_n[A-1]) ? (A'(0) - dot_n) : dot_n;
        zero_q <= (na_n == '0) || (nb_n == '0);
      end
      ST_MUL: begin
        x_q   <= P'(na_q) * P'(nb_q);
        res_q <= '0;
        bit_q <= P'(1) << (P - 2);
      end
      ST_SQRT: begin
        if (x_q >= trial) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        rem_q <= '0;
        quo_q <= '0;
        dvd_q <= {mag_q, bvs_pkg::FRAC_BITS'(0)};
      end
      ST_DIV: begin
        if (dtrial >= {1'b0, res_q[A-1:0]}) begin
          rem_q <= A'(dtrial - {1'b0, res_q[A-1:0]});
          quo_q <= {quo_q[D-2:0], 1'b1};
        end else begin
          rem_q <= dtrial[A-1:0];
          quo_q <= {quo_q[D-2:0], 1'b0};
        end
        dvd_q <= dvd_q << 1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/byte_vector_similarity.sv =====
// ----------------------------------------------------------------------------
// byte_vector_similarity
// Dot product, squared L2 distance and cosine similarity over byte vectors.
// ----------------------------------------------------------------------------
// Input beats carry up to eight byte lane pairs, a lane count and a last
// flag; each is taken when in_valid_i and in_ready_o are high. The front
// registers the lane products and sums them into a two-entry queue; the
// back adds one queued beat a cycle, while in its accumulate state, to the
// three 32-bit sums. Beats stream at one per cycle while the back keeps up.
// The beat marked last yields one result on value_o, held in an output
// register until out_ready_i; dot and L2 results pass through the front
// register, the queue and the output register. Cosine takes a multiply, a
// 32-step root, a 62-step divide and a finish state, and the front can
// still fill the queue meanwhile; a zero norm skips straight to the finish.
// A stalled receiver holds the output register; the back then stops
// popping at the next dot or L2 last beat, or waits in the finish state
// after a cosine one, and the queue backs up to the input.
// Reset clears the sums, the queue and the metric register (dot, signed).
// The metric is written over the APB port at addresses 0 to 3 (paddr[2] low).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_vector_similarity (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] a_lanes_i,
  input  logic [63:0] b_lanes_i,
  input  logic [3:0]  valid_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o
);

  logic [2:0]          metric_q;
  logic                push, hold;
  bvs_pkg::entry_t     f_entry, q_entry;
  bvs_pkg::fifo_stat_t fstat;
  bvs_pkg::back_stat_t bstat;

  // Hold the metric register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, metric_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= bvs_pkg::METRIC_DOT_S8;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      metric_q <= pwdata[2:0];
    end
  end

  bvs_front u_front (
    .clk_i, .rst_ni,
    .metric_i(metric_q),
    .in_valid_i, .in_ready_o,
    .a_lanes_i, .b_lanes_i, .valid_count_i, .last_i,
    .push_o(push), .entry_o(f_entry), .full_i(fstat.full), .hold_o(hold)
  );

  bvs_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .entry_i(f_entry),
    .pop_i(bstat.pop), .entry_o(q_entry), .stat_o(fstat)
  );

  bvs_back u_back (
    .clk_i, .rst_ni,
    .entry_i(q_entry), .empty_i(fstat.empty), .stat_o(bstat),
    .out_valid_o, .out_ready_i, .value_o
  );

  `BVS_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && fstat.full)
  `BVS_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, bstat.pop && fstat.empty)
  `BVS_ASSERT(a_busy_no_pop, clk_i, rst_ni, bstat.busy |-> !bstat.pop)
  `BVS_ASSERT(a_stall_holds, clk_i, rst_ni, !in_ready_o |-> (hold && fstat.full))

endmodule
